// File: src/dgcd_pkg.sv
package dgcd_pkg;

    // Fixed field widths of the request and the configuration register
    localparam int VERTEX_W = 5;
    localparam int VCOUNT_W = 6;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

    // Request type codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
        logic                edge_present;
    } t_req;

    typedef struct packed {
        logic cycle_found;
        logic is_check_result;
    } t_result;

    // Per-cycle access control of one memory port
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// File: src/directed_graph_cycle_detect.sv
// Directed-graph cycle detector. A request with req_type write stores one
// adjacency bit (from_vertex -> to_vertex) by reading its row and writing it
// back, and is answered from the S_WRITE state; a request whose vertex lies
// at or above MAX_VERTICES is acknowledged but changes nothing. A check
// request runs a depth-first search over the first vertex_count vertices
// (saturated at MAX_VERTICES) and answers with cycle_found; a self-loop
// counts as a cycle. busy is high from the cycle after a request is taken
// until its answer is registered. The search visits one adjacency bit per
// cycle while it scans a row, out of a row memory with one read port and
// one write port; it steps through the root vertices in a root state, and
// on each return to a parent vertex it reads that vertex's frame back from
// the stack memory in a pop state. o_strobe is high for exactly one cycle
// when the answer is registered on o_result; there is no back-pressure, so
// capture it in that cycle. The adjacency store reads as empty after reset
// without any clearing pass. Write vertex_count only while busy is low.
module directed_graph_cycle_detect
    import dgcd_pkg::*;
#(
    parameter int MAX_VERTICES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  t_req                i_req,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [VCOUNT_W-1:0] i_cfg_data,
    output logic                o_strobe,
    output t_result             o_result
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = AW + 1;
    localparam int FW = AW + NW;

    logic [VCOUNT_W-1:0]     r_vertex_count;

    t_mem_ctl                adj_ctl;
    logic [AW-1:0]           adj_rd_addr;
    logic [AW-1:0]           adj_wr_addr;
    logic [MAX_VERTICES-1:0] adj_wr_row;
    logic [MAX_VERTICES-1:0] adj_row;

    t_mem_ctl                stk_ctl;
    logic [AW-1:0]           stk_addr;
    logic [FW-1:0]           stk_wr_frame;
    logic [FW-1:0]           stk_rd_frame;

    // Vertex count register: write-only, taken whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Sequencer: write read-modify-write and the depth-first walk
    dgcd_search #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_req          (i_req),
        .i_vertex_count (r_vertex_count),
        .busy           (busy),
        .o_adj_ctl      (adj_ctl),
        .o_adj_rd_addr  (adj_rd_addr),
        .o_adj_wr_addr  (adj_wr_addr),
        .o_adj_wr_row   (adj_wr_row),
        .i_adj_row      (adj_row),
        .o_stk_ctl      (stk_ctl),
        .o_stk_addr     (stk_addr),
        .o_stk_wr_frame (stk_wr_frame),
        .i_stk_rd_frame (stk_rd_frame),
        .o_strobe       (o_strobe),
        .o_result       (o_result)
    );

    // Adjacency matrix, one row per source vertex
    dgcd_adj_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (adj_ctl),
        .i_rd_addr (adj_rd_addr),
        .i_wr_addr (adj_wr_addr),
        .i_wr_row  (adj_wr_row),
        .o_rd_row  (adj_row)
    );

    // Parent frames of the search: vertex and next neighbor to scan
    dgcd_stack #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_stack (
        .i_clk      (i_clk),
        .i_ctl      (stk_ctl),
        .i_addr     (stk_addr),
        .i_wr_frame (stk_wr_frame),
        .o_rd_frame (stk_rd_frame)
    );

endmodule

// File: src/dgcd_adj_store.sv
module dgcd_adj_store
    import dgcd_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    localparam int AW = $clog2(MAX_VERTICES)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mem_ctl                i_ctl,
    input  logic [AW-1:0]           i_rd_addr,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [MAX_VERTICES-1:0] i_wr_row,
    output logic [MAX_VERTICES-1:0] o_rd_row
);

    logic [MAX_VERTICES-1:0] r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_rd_q;
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic                    r_rd_vld;

    // Row storage and registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_ctl.rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // A row never written since reset reads as no edges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_q : '0;

endmodule

// File: src/dgcd_stack.sv
module dgcd_stack
    import dgcd_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    localparam int AW = $clog2(MAX_VERTICES),
    localparam int FW = 2 * AW + 1
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_addr,
    input  logic [FW-1:0] i_wr_frame,
    output logic [FW-1:0] o_rd_frame
);

    logic [FW-1:0] r_mem [MAX_VERTICES];
    logic [FW-1:0] r_rd_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_frame;
        end
        if (i_ctl.rd_en) begin
            r_rd_q <= r_mem[i_addr];
        end
    end

    assign o_rd_frame = r_rd_q;

endmodule

// File: src/dgcd_search.sv
module dgcd_search
    import dgcd_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    localparam int AW = $clog2(MAX_VERTICES),
    localparam int NW = AW + 1,
    localparam int FW = AW + NW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  t_req                    i_req,
    input  logic [VCOUNT_W-1:0]     i_vertex_count,
    output logic                    busy,
    // adjacency store
    output t_mem_ctl                o_adj_ctl,
    output logic [AW-1:0]           o_adj_rd_addr,
    output logic [AW-1:0]           o_adj_wr_addr,
    output logic [MAX_VERTICES-1:0] o_adj_wr_row,
    input  logic [MAX_VERTICES-1:0] i_adj_row,
    // search stack
    output t_mem_ctl                o_stk_ctl,
    output logic [AW-1:0]           o_stk_addr,
    output logic [FW-1:0]           o_stk_wr_frame,
    input  logic [FW-1:0]           i_stk_rd_frame,
    // result
    output logic                    o_strobe,
    output t_result                 o_result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;

    localparam logic [NW-1:0] DEPTH_MAX = NW'(MAX_VERTICES);
    localparam logic [NW-1:0] ONE       = NW'(1);
    localparam logic [NW-1:0] TWO       = NW'(2);

    logic [2:0]              r_state, n_state;
    logic [AW-1:0]           r_u, n_u;
    logic [NW-1:0]           r_next, n_next;
    logic [NW-1:0]           r_depth, n_depth;
    logic [NW-1:0]           r_root, n_root;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [MAX_VERTICES-1:0] r_onstk, n_onstk;
    logic [VERTEX_W-1:0]     r_wr_from, n_wr_from;
    logic [VERTEX_W-1:0]     r_wr_to, n_wr_to;
    logic                    r_wr_edge, n_wr_edge;
    logic                    r_strobe, n_strobe;
    t_result                 r_result, n_result;

    logic [NW-1:0]           act_n;
    logic [AW-1:0]           root_idx;
    logic [AW-1:0]           w_idx;
    logic [NW-1:0]           depth_m1;
    logic [NW-1:0]           depth_m2;
    logic [NW-1:0]           next_p1;
    logic [AW-1:0]           pop_vertex;
    logic [NW-1:0]           pop_next;
    logic [MAX_VERTICES-1:0] wr_mask;
    logic                    wr_ok;

    // Vertices in use, saturated at the built size
    assign act_n = (32'(i_vertex_count) > MAX_VERTICES) ? DEPTH_MAX : NW'(i_vertex_count);

    assign root_idx = r_root[AW-1:0];
    assign w_idx    = r_next[AW-1:0];
    assign depth_m1 = r_depth - ONE;
    assign depth_m2 = r_depth - TWO;
    assign next_p1  = r_next + ONE;

    assign pop_vertex = i_stk_rd_frame[FW-1:NW];
    assign pop_next   = i_stk_rd_frame[NW-1:0];

    assign wr_mask = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << AW'(r_wr_to);
    assign wr_ok   = (32'(r_wr_from) < MAX_VERTICES) && (32'(r_wr_to) < MAX_VERTICES);

    always_comb begin
        n_state   = r_state;
        n_u       = r_u;
        n_next    = r_next;
        n_depth   = r_depth;
        n_root    = r_root;
        n_visited = r_visited;
        n_onstk   = r_onstk;
        n_wr_from = r_wr_from;
        n_wr_to   = r_wr_to;
        n_wr_edge = r_wr_edge;
        n_strobe  = 1'b0;
        n_result  = r_result;

        o_adj_ctl      = '0;
        o_adj_rd_addr  = r_u;
        o_adj_wr_addr  = AW'(r_wr_from);
        o_adj_wr_row   = (i_adj_row & ~wr_mask) | (r_wr_edge ? wr_mask : '0);
        o_stk_ctl      = '0;
        o_stk_addr     = depth_m1[AW-1:0];
        o_stk_wr_frame = {r_u, next_p1};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.req_type == REQ_CHECK) begin
                        n_visited = '0;
                        n_onstk   = '0;
                        n_depth   = '0;
                        n_root    = '0;
                        n_state   = S_ROOT;
                    end else begin
                        o_adj_ctl.rd_en = 1'b1;
                        o_adj_rd_addr   = AW'(i_req.from_vertex);
                        n_wr_from       = i_req.from_vertex;
                        n_wr_to         = i_req.to_vertex;
                        n_wr_edge       = i_req.edge_present;
                        n_state         = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                o_adj_ctl.wr_en          = wr_ok;
                n_strobe                 = 1'b1;
                n_result.cycle_found     = 1'b0;
                n_result.is_check_result = 1'b0;
                n_state                  = S_IDLE;
            end
            S_ROOT: begin
                if (r_root >= act_n) begin
                    n_strobe                 = 1'b1;
                    n_result.cycle_found     = 1'b0;
                    n_result.is_check_result = 1'b1;
                    n_onstk                  = '0;
                    n_depth                  = '0;
                    n_state                  = S_IDLE;
                end else if (r_visited[root_idx]) begin
                    n_root = r_root + ONE;
                end else begin
                    n_visited[root_idx] = 1'b1;
                    n_onstk[root_idx]   = 1'b1;
                    n_u                 = root_idx;
                    n_next              = '0;
                    n_depth             = ONE;
                    o_adj_ctl.rd_en     = 1'b1;
                    o_adj_rd_addr       = root_idx;
                    n_state             = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_next >= act_n) begin
                    n_onstk[r_u] = 1'b0;
                    if (r_depth == ONE) begin
                        n_root  = r_root + ONE;
                        n_depth = '0;
                        n_state = S_ROOT;
                    end else begin
                        o_stk_ctl.rd_en = 1'b1;
                        o_stk_addr      = depth_m2[AW-1:0];
                        n_depth         = depth_m1;
                        n_state         = S_POP;
                    end
                end else begin
                    n_next = next_p1;
                    if (i_adj_row[w_idx]) begin
                        if (r_onstk[w_idx]) begin
                            n_strobe                 = 1'b1;
                            n_result.cycle_found     = 1'b1;
                            n_result.is_check_result = 1'b1;
                            n_onstk                  = '0;
                            n_depth                  = '0;
                            n_state                  = S_IDLE;
                        end else if (!r_visited[w_idx] && (r_depth < DEPTH_MAX)) begin
                            o_stk_ctl.wr_en  = 1'b1;
                            n_visited[w_idx] = 1'b1;
                            n_onstk[w_idx]   = 1'b1;
                            n_u              = w_idx;
                            n_next           = '0;
                            n_depth          = r_depth + ONE;
                            o_adj_ctl.rd_en  = 1'b1;
                            o_adj_rd_addr    = w_idx;
                        end
                    end
                end
            end
            S_POP: begin
                n_u             = pop_vertex;
                n_next          = pop_next;
                o_adj_ctl.rd_en = 1'b1;
                o_adj_rd_addr   = pop_vertex;
                n_state         = S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_root    <= '0;
            r_visited <= '0;
            r_onstk   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_root    <= n_root;
            r_visited <= n_visited;
            r_onstk   <= n_onstk;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u       <= n_u;
        r_next    <= n_next;
        r_wr_from <= n_wr_from;
        r_wr_to   <= n_wr_to;
        r_wr_edge <= n_wr_edge;
        r_result  <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
